@@ rtl/plfp_pkg.sv @@
// plfp_pkg: shared types and constants for the parallel-line file transfer port
// no dependencies; compile first
`default_nettype none

package plfp_pkg;

  // bus access kinds
  typedef enum logic [1:0] {
    CMD_READ       = 2'd0,
    CMD_WORD_WRITE = 2'd1,
    CMD_BYTE_WRITE = 2'd2
  } plfp_cmd_t;

  // register offsets
  typedef enum logic [1:0] {
    OFS_RD_STATUS = 2'd0,
    OFS_RD_DATA   = 2'd1,
    OFS_WR_STATUS = 2'd2,
    OFS_WR_DATA   = 2'd3
  } plfp_ofs_t;

  // framing phases; the tail code 4 is never entered
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_NAME   = 3'd1,
    PH_HEADER = 3'd2,
    PH_BODY   = 3'd3
  } plfp_phase_t;

  localparam logic [7:0]  STATUS_READY  = 8'h80;
  localparam logic [7:0]  REPLY_UNKNOWN = 8'hFF;
  localparam logic [7:0]  OP_STOP       = 8'd0;
  localparam logic [7:0]  OP_MAX        = 8'd4;
  localparam logic [7:0]  OP_SEND       = 8'd2;
  localparam logic [15:0] HEADER_BYTES  = 16'd4;

  // header byte positions
  localparam logic [1:0] HDR_ADDR_LO = 2'd0;
  localparam logic [1:0] HDR_ADDR_HI = 2'd1;
  localparam logic [1:0] HDR_LEN_LO  = 2'd2;
  localparam logic [1:0] HDR_LEN_HI  = 2'd3;

  // framer status seen by the top level
  typedef struct packed {
    plfp_phase_t phase;
    logic [7:0]  reply;
    logic [15:0] address;
    logic [15:0] length;
  } plfp_frame_t;

endpackage

`default_nettype wire

@@ rtl/plfp_if.sv @@
// plfp_req_if / plfp_rsp_if: valid-ready channels for bus accesses and results
// no dependencies
`default_nettype none

interface plfp_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [1:0] reg_offset;
  logic [7:0] write_data;

  modport source (output valid, output command, output reg_offset, output write_data,
                  input ready);
  modport sink (input valid, input command, input reg_offset, input write_data,
                output ready);
endinterface

interface plfp_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [2:0]  phase;
  logic [15:0] frame_address;
  logic [15:0] frame_length;

  modport source (output valid, output read_data, output phase, output frame_address,
                  output frame_length, input ready);
  modport sink (input valid, input read_data, input phase, input frame_address,
                input frame_length, output ready);
endinterface

`default_nettype wire

@@ rtl/plfp_framer.sv @@
// plfp_framer: framing state machine fed one byte per feed strobe
// depends on plfp_pkg
`default_nettype none

module plfp_framer #(
  parameter int NAME_BYTES = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 feed,
  input  wire logic [7:0]           data,
  output plfp_pkg::plfp_frame_t     status
);
  import plfp_pkg::*;

  plfp_phase_t phase, phase_next;
  logic [15:0] count, count_next;
  logic [7:0]  reply, reply_next;
  logic [15:0] address, address_next;
  logic [15:0] length, length_next;
  logic [15:0] count_inc;

  assign count_inc = count + 16'd1;

  // next phase
  always_comb begin
    phase_next = phase;
    if (feed) begin
      unique case (phase)
        PH_IDLE:   if (data == OP_SEND) phase_next = PH_NAME;
        PH_NAME:   if (count_inc == 16'(NAME_BYTES)) phase_next = PH_HEADER;
        PH_HEADER: if (count_inc == HEADER_BYTES) phase_next = PH_BODY;
        PH_BODY:   if (count_inc == length) phase_next = PH_IDLE;
        default:   phase_next = phase;
      endcase
    end
  end

  // counter, reply and header fields
  always_comb begin
    count_next   = count;
    reply_next   = reply;
    address_next = address;
    length_next  = length;
    if (feed) begin
      unique case (phase)
        PH_IDLE: begin
          if (data == OP_STOP) begin
            reply_next = reply;
          end else if (data <= OP_MAX) begin
            reply_next = data;
            if (data == OP_SEND) count_next = 16'd0;
          end else begin
            reply_next = REPLY_UNKNOWN;
          end
        end
        PH_NAME: begin
          reply_next = 8'd0;
          count_next = (count_inc == 16'(NAME_BYTES)) ? 16'd0 : count_inc;
        end
        PH_HEADER: begin
          case (count[1:0])
            HDR_ADDR_LO: address_next = {8'd0, data};
            HDR_ADDR_HI: address_next = {data, address[7:0]};
            HDR_LEN_LO:  length_next  = {8'd0, data};
            HDR_LEN_HI:  length_next  = {data, length[7:0]};
            default:     address_next = address;
          endcase
          count_next = (count_inc == HEADER_BYTES) ? 16'd0 : count_inc;
        end
        PH_BODY: begin
          count_next = (count_inc == length) ? 16'd0 : count_inc;
        end
        default: count_next = count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      count   <= 16'd0;
      reply   <= 8'd0;
      address <= 16'd0;
      length  <= 16'd0;
    end else begin
      phase   <= phase_next;
      count   <= count_next;
      reply   <= reply_next;
      address <= address_next;
      length  <= length_next;
    end
  end

  assign status = '{phase: phase, reply: reply, address: address, length: length};

`ifndef SYNTH
  a_header_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HEADER) |-> (count < HEADER_BYTES))
    else $error("header byte count out of range");

  a_name_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_NAME) |-> (count < 16'(NAME_BYTES)))
    else $error("name byte count out of range");

  a_header_done: assert property (@(posedge clk) disable iff (rst)
    (feed && phase == PH_HEADER && count[1:0] == HDR_LEN_HI)
      |=> (phase == PH_BODY && count == 16'd0))
    else $error("header did not hand over to body");

  a_body_done: assert property (@(posedge clk) disable iff (rst)
    (feed && phase == PH_BODY && count_inc == length)
      |=> (phase == PH_IDLE && count == 16'd0))
    else $error("body did not end at header length");

  a_no_feed_hold: assert property (@(posedge clk) disable iff (rst)
    !feed |=> ($stable(phase) && $stable(count) && $stable(reply)))
    else $error("framer state moved without a byte");
`endif

endmodule

`default_nettype wire

@@ rtl/parallel_line_file_transfer_port_core.sv @@
// parallel_line_file_transfer_port_core: four-register parallel-line port top level
// depends on plfp_pkg, plfp_req_if, plfp_rsp_if and plfp_framer
//
//   channel  dir  fields                                          word
//   req      in   command, reg_offset, write_data                 one bus access
//   rsp      out  read_data, phase, frame_address, frame_length   one result
//
// one access is taken per cycle while rsp is not stalled; its result appears in the cycle after acceptance
// rsp is a single output register; req stays ready whenever that register is empty
// or is being emptied in the same cycle, so a full rate flow needs no bubbles
// a stall on rsp holds the result and the framer state until the word is taken
// rst is synchronous: framer goes to idle with reply, count and header cleared
`default_nettype none

module parallel_line_file_transfer_port_core #(
  parameter int NAME_BYTES = 10   // name bytes in a frame, 1 to 64
) (
  input wire logic   clk,
  input wire logic   rst,
  plfp_req_if.sink   req,
  plfp_rsp_if.source rsp
);
  import plfp_pkg::*;

  plfp_frame_t status;
  logic        accept;
  logic        feed;
  logic [7:0]  read_data;
  logic [7:0]  read_data_next;
  logic        out_valid;

  // take a new access whenever the result slot is free or draining
  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  // bytes that reach the framer: word writes to the data register, any byte write
  always_comb begin
    feed = 1'b0;
    if (accept) begin
      case (req.command)
        CMD_WORD_WRITE: feed = (req.reg_offset == OFS_WR_DATA);
        CMD_BYTE_WRITE: feed = 1'b1;
        default:        feed = 1'b0;
      endcase
    end
  end

  // register read decode; writes and the unused command read as zero
  always_comb begin
    read_data_next = 8'd0;
    if (req.command == CMD_READ) begin
      unique case (req.reg_offset)
        OFS_RD_STATUS: read_data_next = STATUS_READY;
        OFS_RD_DATA:   read_data_next = status.reply;
        OFS_WR_STATUS: read_data_next = STATUS_READY;
        OFS_WR_DATA:   read_data_next = 8'd0;
        default:       read_data_next = 8'd0;
      endcase
    end
  end

  plfp_framer #(
    .NAME_BYTES(NAME_BYTES)
  ) u_framer (
    .clk    (clk),
    .rst    (rst),
    .feed   (feed),
    .data   (req.write_data),
    .status (status)
  );

  // result register: valid is control, read data is payload
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_data <= read_data_next;
    end
  end

  // framer state only moves on an accepted word, so it stands for the held result
  assign rsp.valid         = out_valid;
  assign rsp.read_data     = read_data;
  assign rsp.phase         = status.phase;
  assign rsp.frame_address = status.address;
  assign rsp.frame_length  = status.length;

endmodule

`default_nettype wire
